// ===== rtl/rbd_pkg.sv =====
// shared constants and types of the rgb565 2x2 box downscaler
package rbd_pkg;

  // source frame geometry
  localparam int SrcWidth  = 112;
  localparam int SrcHeight = 112;

  localparam int HalfW = SrcWidth / 2;
  localparam int HalfH = SrcHeight / 2;

  localparam int ColW = $clog2(SrcWidth);
  localparam int RowW = $clog2(SrcHeight);
  localparam int IdxW = (HalfW > 1) ? $clog2(HalfW) : 1;

  localparam logic [ColW-1:0] LastCol     = ColW'(SrcWidth - 1);
  localparam logic [RowW-1:0] LastRow     = RowW'(SrcHeight - 1);
  localparam logic [ColW-1:0] LastPairCol = ColW'(2 * HalfW - 1);
  localparam logic [RowW-1:0] LastPairRow = RowW'(2 * HalfH - 1);
  localparam bit              OddWidth    = (SrcWidth % 2) == 1;
  localparam bit              OddHeight   = (SrcHeight % 2) == 1;

  // queue between front and back
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // what the back end does with a queued pair
  typedef enum logic {
    OpStore = 1'b0,
    OpEmit  = 1'b1
  } pair_op_e;

  // horizontal pair sum of one source row
  typedef struct packed {
    logic [5:0] r;
    logic [6:0] g;
    logic [5:0] b;
  } pair_sum_t;

  typedef struct packed {
    pair_op_e        op;
    logic [IdxW-1:0] idx;
    pair_sum_t       pair;
    logic            last;
  } pair_job_t;

endpackage

// ===== rtl/rgb565_box_downscale_2x2.sv =====
// top level of the rgb565 2x2 box downscaler
//
//   channel  | signals                                | direction
//   ---------+----------------------------------------+----------
//   source   | in_valid_i, in_stall_o, pixel_in_i     | in
//   result   | out_valid_o, out_stall_i, pixel_out_o, | out
//            | frame_end_o                            |
//
// one source pixel per clock is accepted while in_stall_o is low; each result
// leaves after the transfer of the bottom-right pixel of its block by way of the
// job queue, the line store read register and the output register
// rst_ni clears counters, the pending pixel, the queue and all valid flags;
// the line store needs no clearing since every entry is written on an even
// row before the following odd row reads it
// in_stall_o rises only when the four-entry job queue is full; out_stall_i
// holds the output register and backs up into the queue
module rgb565_box_downscale_2x2 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] pixel_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_out_o,
  output logic        frame_end_o
);

  logic               accept;
  logic               push;
  rbd_pkg::pair_job_t push_job;
  logic               q_full;
  logic               head_valid;
  rbd_pkg::pair_job_t head_job;
  logic               pop;

  // source transfer completes whenever the queue has room
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // front: counts position, pairs even/odd columns, tags jobs store or emit
  rbd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .pixel_in_i (pixel_in_i),
    .push_o     (push),
    .job_o      (push_job)
  );

  // decouples the pixel stream from result stalls
  rbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_job),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head_job),
    .pop_i        (pop)
  );

  // back: line store write on even rows, read and average on odd rows
  rbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

// ===== rtl/rbd_front.sv =====
// front end: position counters, horizontal pairing and job classification
module rbd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [15:0]       pixel_in_i,
  output logic              push_o,
  output rbd_pkg::pair_job_t job_o
);

  logic [rbd_pkg::ColW-1:0] col_q, col_d;
  logic [rbd_pkg::RowW-1:0] row_q, row_d;
  logic [4:0]               h_r_q, h_b_q;
  logic [5:0]               h_g_q;
  logic [4:0]               px_r, px_b;
  logic [5:0]               px_g;
  logic                     in_block;
  logic                     col_odd;

  assign px_r = pixel_in_i[15:11];
  assign px_g = pixel_in_i[10:5];
  assign px_b = pixel_in_i[4:0];

  // unpaired last column or row is consumed and ignored
  assign in_block = !(rbd_pkg::OddWidth && (col_q == rbd_pkg::LastCol)) &&
                    !(rbd_pkg::OddHeight && (row_q == rbd_pkg::LastRow));
  assign col_odd  = col_q[0];

  assign push_o = accept_i && in_block && col_odd;

  always_comb begin
    job_o.op     = row_q[0] ? rbd_pkg::OpEmit : rbd_pkg::OpStore;
    job_o.idx    = rbd_pkg::IdxW'(col_q >> 1);
    job_o.pair.r = {1'b0, h_r_q} + {1'b0, px_r};
    job_o.pair.g = {1'b0, h_g_q} + {1'b0, px_g};
    job_o.pair.b = {1'b0, h_b_q} + {1'b0, px_b};
    job_o.last   = (row_q == rbd_pkg::LastPairRow) && (col_q == rbd_pkg::LastPairCol);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (col_q == rbd_pkg::LastCol) begin
        col_d = '0;
        row_d = (row_q == rbd_pkg::LastRow) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // pending even-column pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_r_q <= '0;
      h_g_q <= '0;
      h_b_q <= '0;
    end else if (accept_i && in_block && !col_odd) begin
      h_r_q <= px_r;
      h_g_q <= px_g;
      h_b_q <= px_b;
    end
  end

endmodule

// ===== rtl/rbd_queue.sv =====
// short job queue between front and back end
module rbd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rbd_pkg::pair_job_t push_data_i,
  output logic               full_o,
  output logic               head_valid_o,
  output rbd_pkg::pair_job_t head_o,
  input  logic               pop_i
);

  rbd_pkg::pair_job_t        slots_q [rbd_pkg::QueueDepth];
  logic [rbd_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [rbd_pkg::QCntW-1:0] count_q;

  assign full_o       = count_q == rbd_pkg::QCntW'(rbd_pkg::QueueDepth);
  assign head_valid_o = count_q != '0;
  assign head_o       = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rbd_back.sv =====
// back end: half-width line store, vertical combine and output register
module rbd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  rbd_pkg::pair_job_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        pixel_out_o,
  output logic               frame_end_o
);

  rbd_pkg::pair_sum_t line_q [rbd_pkg::HalfW];
  rbd_pkg::pair_sum_t rdata_q;
  rbd_pkg::pair_sum_t s1_pair_q;
  logic               s1_last_q;
  logic               s1_valid_q, s1_valid_d;
  logic               s1_adv;
  logic               pop_emit;
  logic               out_valid_q, out_valid_d;
  logic [15:0]        pixel_q;
  logic               frame_end_q;
  logic [6:0]         sum_r, sum_b;
  logic [7:0]         sum_g;

  assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign pop_o    = head_valid_i &&
                    ((head_i.op == rbd_pkg::OpStore) || !s1_valid_q || s1_adv);
  assign pop_emit = pop_o && (head_i.op == rbd_pkg::OpEmit);

  // line store port
  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.op == rbd_pkg::OpStore)) begin
      line_q[head_i.idx] <= head_i.pair;
    end
    if (pop_emit) begin
      rdata_q <= line_q[head_i.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_emit) begin
      s1_pair_q <= head_i.pair;
      s1_last_q <= head_i.last;
    end
  end

  assign sum_r = {1'b0, s1_pair_q.r} + {1'b0, rdata_q.r};
  assign sum_g = {1'b0, s1_pair_q.g} + {1'b0, rdata_q.g};
  assign sum_b = {1'b0, s1_pair_q.b} + {1'b0, rdata_q.b};

  assign s1_valid_d  = pop_emit || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pixel_q     <= {sum_r[6:2], sum_g[7:2], sum_b[6:2]};
      frame_end_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;
  assign frame_end_o = frame_end_q;

endmodule
